>>> rtl/photon_time_pixel_binner_assert.svh
// Assertion macros for the photon time pixel binner.
// Included by the top level; no other dependencies.
`ifndef PHOTON_TIME_PIXEL_BINNER_ASSERT_SVH
`define PHOTON_TIME_PIXEL_BINNER_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold on every clock edge outside reset
`define PTB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication outside reset
`define PTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define PTB_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/ptb_pkg.sv
// Package for the photon time pixel binner: sizes, command codes and
// request structs shared by the stores and the top level. No dependencies.
`default_nettype none

package ptb_pkg;

	localparam int MAX_PIXELS = 65535;
	localparam int TIME_BITS  = 48;
	localparam int COUNT_BITS = 32;

	localparam int PIX_W    = 16;                 // pixel index, bin and register width
	localparam int BND_AW   = 16;                 // boundary table address
	localparam int PTR_W    = BND_AW + 1;         // pointer reaches pixel_count + 1
	localparam int CNT_AW   = $clog2(MAX_PIXELS);
	localparam int CFG_IDX_W = 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOLD_PERIOD = 1'd1;

	// Command codes
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_PHOT  = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	typedef struct packed {
		logic                 wr_en;
		logic [BND_AW-1:0]    wr_addr;
		logic [TIME_BITS-1:0] wr_data;
		logic                 rd_en;
		logic [BND_AW-1:0]    rd_addr;
	} bnd_req_t;

	typedef struct packed {
		logic                  wr_en;
		logic [CNT_AW-1:0]     wr_addr;
		logic [COUNT_BITS-1:0] wr_data;
		logic                  rd_en;
		logic [CNT_AW-1:0]     rd_addr;
	} cnt_req_t;

endpackage

`default_nettype wire

>>> rtl/ptb_if.sv
// Channel interfaces of the photon time pixel binner: command words in,
// result words out. Depends on ptb_pkg.
`default_nettype none

interface ptb_in_if;
	import ptb_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [1:0]           cmd;
	logic [PIX_W-1:0]     index;
	logic [TIME_BITS-1:0] time_value;

	modport source (output valid, cmd, index, time_value, input ready);
	modport sink   (input valid, cmd, index, time_value, output ready);
endinterface

interface ptb_out_if;
	import ptb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [PIX_W-1:0]      pixel_bin;
	logic [COUNT_BITS-1:0] count_value;

	modport source (output valid, pixel_bin, count_value, input ready);
	modport sink   (input valid, pixel_bin, count_value, output ready);
endinterface

`default_nettype wire

>>> rtl/ptb_bound_store.sv
// Boundary time table: one synchronous RAM, one write and one read port,
// plus a register copy of boundary 0 for the pre-frame test. Uses ptb_pkg.
`default_nettype none

module ptb_bound_store (
	input  wire                           clk,
	input  ptb_pkg::bnd_req_t             req,
	output logic [ptb_pkg::TIME_BITS-1:0] rdata,
	output logic [ptb_pkg::TIME_BITS-1:0] first
);
	import ptb_pkg::*;

	logic [TIME_BITS-1:0] mem [2**BND_AW];
	logic [TIME_BITS-1:0] rdata_q;
	logic [TIME_BITS-1:0] first_q;

	// RAM, read data registered
	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en)
			rdata_q <= mem[req.rd_addr];
	end

	// shadow of entry 0
	always_ff @(posedge clk) begin
		if (req.wr_en && req.wr_addr == '0)
			first_q <= req.wr_data;
	end

	assign rdata = rdata_q;
	assign first = first_q;

endmodule

`default_nettype wire

>>> rtl/ptb_count_store.sv
// Per-pixel photon count RAM with its clearing sweep (after reset and on
// start, one entry per cycle). Uses ptb_pkg.
`default_nettype none

module ptb_count_store (
	input  wire                            clk,
	input  wire                            arst_n,
	input  ptb_pkg::cnt_req_t              req,
	input  wire                            clr_go,
	output logic [ptb_pkg::COUNT_BITS-1:0] rdata,
	output logic                           busy
);
	import ptb_pkg::*;

	localparam logic [CNT_AW-1:0] LAST = CNT_AW'(MAX_PIXELS - 1);

	logic [COUNT_BITS-1:0] mem [MAX_PIXELS];
	logic [COUNT_BITS-1:0] rdata_q;
	logic                  busy_q;
	logic [CNT_AW-1:0]     clr_addr_q;
	logic                  we;
	logic [CNT_AW-1:0]     waddr;
	logic [COUNT_BITS-1:0] wdata;

	// sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_go) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			if (clr_addr_q == LAST)
				busy_q <= 1'b0;
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// sweep owns the write port while busy
	always_comb begin
		we    = busy_q | req.wr_en;
		waddr = busy_q ? clr_addr_q : req.wr_addr;
		wdata = busy_q ? '0 : req.wr_data;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (req.rd_en)
			rdata_q <= mem[req.rd_addr];
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

`default_nettype wire

>>> rtl/photon_time_pixel_binner.sv
// Top level of the photon time pixel binner: command sequencer, registers
// and output word. Depends on ptb_pkg, ptb_if, ptb_bound_store, ptb_count_store.
`default_nettype none
`include "photon_time_pixel_binner_assert.svh"

// Every command word gives exactly one result word. A boundary load or a
// start gives its result from EXEC. A count read goes through EXEC and RD,
// or gives its result from EXEC when the index lies beyond the count RAM. A
// photon gives its result from EXEC if it is before boundary 0, or if the
// pointer is already past the last pixel. A photon that walks off the last
// pixel goes on from EXEC to WALK, steps over the boundaries there and gives
// its result from WALK. A photon that lands in a pixel goes through EXEC, WALK
// and CNT, or gives its result from WALK when that pixel lies beyond the count
// RAM. The walk reads the boundary RAM one entry per cycle.
// After reset and after each start the count RAM is swept to zero, and no
// command word is taken during the sweep. Configuration writes are taken at
// any time. A new command word is taken while a result word waits.
module photon_time_pixel_binner (
	input  wire                          clk,
	input  wire                          arst_n,
	ptb_in_if.sink                       in_ch,
	ptb_out_if.source                    out_ch,
	input  wire                          cfg_we,
	input  wire [ptb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [ptb_pkg::PIX_W-1:0]     cfg_wdata
);
	import ptb_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_WALK = 3'd2;
	localparam logic [2:0] ST_CNT  = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;

	logic [2:0]            state_q, state_d;
	logic [PIX_W-1:0]      pixel_count_q, fold_period_q;
	logic [1:0]            cmd_q;
	logic [PIX_W-1:0]      index_q;
	logic [TIME_BITS-1:0]  time_q;
	logic [PTR_W-1:0]      ptr_q, ptr_d;
	logic [PIX_W-1:0]      folded_q, folded_d;
	logic                  out_valid_q;
	logic [PIX_W-1:0]      bin_q;
	logic [COUNT_BITS-1:0] count_q;

	logic                  accept, out_free, emit, clr_go, clr_busy;
	logic [PIX_W-1:0]      emit_bin;
	logic [COUNT_BITS-1:0] emit_cnt;
	bnd_req_t              bnd_req;
	cnt_req_t              cnt_req;
	logic [TIME_BITS-1:0]  bnd_rdata, bnd_first;
	logic [COUNT_BITS-1:0] cnt_rdata;
	logic [PTR_W-1:0]      ptr_inc;
	logic                  ptr_past, ptr_beyond;
	logic [PIX_W:0]        fold_inc;
	logic [PIX_W-1:0]      fold_next;
	logic                  pix_in_store;

	ptb_bound_store u_bnd (
		.clk   (clk),
		.req   (bnd_req),
		.rdata (bnd_rdata),
		.first (bnd_first)
	);

	ptb_count_store u_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cnt_req),
		.clr_go (clr_go),
		.rdata  (cnt_rdata),
		.busy   (clr_busy)
	);

	assign in_ch.ready = (state_q == ST_IDLE) && !clr_busy;
	assign accept      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= PIX_W'(1);
			fold_period_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PIXEL_COUNT: pixel_count_q <= cfg_wdata;
				REG_FOLD_PERIOD: fold_period_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// command word held for execution
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= in_ch.cmd;
			index_q <= in_ch.index;
			time_q  <= in_ch.time_value;
		end
	end

	// pointer step and wrap counter
	always_comb begin
		ptr_inc      = ptr_q + 1'b1;
		ptr_past     = ptr_inc > {1'b0, pixel_count_q};
		ptr_beyond   = ptr_q > {1'b0, pixel_count_q};
		fold_inc     = {1'b0, folded_q} + 1'b1;
		fold_next    = fold_inc[PIX_W-1:0];
		if (fold_period_q != '0 && fold_inc >= {1'b0, fold_period_q})
			fold_next = '0;
		pix_in_store = 32'(folded_q) < MAX_PIXELS;
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		ptr_d    = ptr_q;
		folded_d = folded_q;
		emit     = 1'b0;
		emit_bin = '0;
		emit_cnt = '0;
		clr_go   = 1'b0;
		bnd_req  = '0;
		cnt_req  = '0;
		bnd_req.wr_addr = index_q;
		bnd_req.wr_data = time_q;
		cnt_req.rd_addr = folded_q;
		cnt_req.wr_addr = folded_q;
		cnt_req.wr_data = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (cmd_q)
					CMD_LOAD: begin
						if (out_free) begin
							bnd_req.wr_en = 1'b1;
							emit          = 1'b1;
							state_d       = ST_IDLE;
						end
					end
					CMD_START: begin
						if (out_free) begin
							ptr_d    = PTR_W'(1);
							folded_d = '0;
							clr_go   = 1'b1;
							emit     = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					CMD_PHOT: begin
						if (time_q < bnd_first || ptr_beyond) begin
							if (out_free) begin
								emit    = 1'b1;
								state_d = ST_IDLE;
							end
						end else begin
							bnd_req.rd_en   = 1'b1;
							bnd_req.rd_addr = ptr_q[BND_AW-1:0];
							state_d         = ST_WALK;
						end
					end
					default: begin
						if (32'(index_q) < MAX_PIXELS) begin
							cnt_req.rd_en   = 1'b1;
							cnt_req.rd_addr = index_q[CNT_AW-1:0];
							state_d         = ST_RD;
						end else if (out_free) begin
							emit    = 1'b1;
							state_d = ST_IDLE;
						end
					end
				endcase
			end
			ST_WALK: begin
				if (time_q >= bnd_rdata) begin
					// boundary passed: step to next pixel
					if (!ptr_past) begin
						ptr_d           = ptr_inc;
						folded_d        = fold_next;
						bnd_req.rd_en   = 1'b1;
						bnd_req.rd_addr = ptr_inc[BND_AW-1:0];
					end else if (out_free) begin
						ptr_d    = ptr_inc;
						folded_d = fold_next;
						emit     = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (pix_in_store) begin
					cnt_req.rd_en = 1'b1;
					state_d       = ST_CNT;
				end else if (out_free) begin
					emit     = 1'b1;
					emit_bin = folded_q + 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_CNT: begin
				if (out_free) begin
					cnt_req.wr_en = 1'b1;
					emit          = 1'b1;
					emit_bin      = folded_q + 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_RD: begin
				if (out_free) begin
					emit     = 1'b1;
					emit_cnt = cnt_rdata;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ptr_q    <= PTR_W'(1);
			folded_q <= '0;
		end else begin
			state_q  <= state_d;
			ptr_q    <= ptr_d;
			folded_q <= folded_d;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			bin_q   <= emit_bin;
			count_q <= emit_cnt;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.pixel_bin   = bin_q;
	assign out_ch.count_value = count_q;

	// checks
	`PTB_ASSERT_IMP(a_no_take_in_clear, clk, arst_n, clr_busy, !in_ch.ready,
		"command word taken during count clear")
	`PTB_ASSERT_IMP(a_emit_slot_free, clk, arst_n, emit, out_free,
		"result word overwrites a waiting word")
	`PTB_ASSERT_IMP(a_cnt_wr_not_clear, clk, arst_n, cnt_req.wr_en, !clr_busy,
		"count update during clear sweep")

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for photon_time_pixel_binner: a directed table of command
// words with expected words, then randomised frames scored against an in-bench binning model.
// Depends on ptb_pkg, ptb_if and the RTL of the block.

module tb;
	import ptb_pkg::*;

	localparam logic [TIME_BITS-1:0] T_MAX = '1;
	localparam int STALL_LIMIT = 300000;	// long enough to cover the count-store sweep
	localparam int TAIL_CYCLES = 16;
	localparam int FRAME_WORDS = 140;
	localparam int GRID_MAX    = 48;		// largest pixel count given a full grid

	typedef struct packed {
		logic [PIX_W-1:0]      bin;
		logic [COUNT_BITS-1:0] cnt;
	} bin_word_t;

	typedef enum bit {ROW_CMD, ROW_REG} row_kind_t;

	// ROW_REG rows carry the register index in index and its data in value
	typedef struct {
		row_kind_t            kind;
		logic [1:0]           cmd;
		logic [PIX_W-1:0]     index;
		logic [TIME_BITS-1:0] value;
		bit                   typed;
		bin_word_t            want;
	} script_row_t;

	typedef struct {
		bit [PIX_W-1:0] pixels;
		bit [PIX_W-1:0] fold;
		bit             refold;
		bit [PIX_W-1:0] fold_later;
		int             idle;
	} frame_plan_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PIX_W-1:0]     cfg_wdata;

	ptb_in_if  cmd_ch ();
	ptb_out_if res_ch ();

	photon_time_pixel_binner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (cmd_ch),
		.out_ch    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Binning model state: boundary marks, per-pixel tallies, walk position
	bit [TIME_BITS-1:0]  mark_time [int];
	bit [COUNT_BITS-1:0] pix_tally [int];
	bit [PTR_W-1:0]      walk_ptr = PTR_W'(1);
	bit [PIX_W-1:0]      fold_pix = '0;
	bit [PIX_W-1:0]      n_pixels = PIX_W'(1);
	bit [PIX_W-1:0]      fold_len = '0;

	bin_word_t   due_words [$];
	bit          pin_on = 1'b0;
	bin_word_t   pin_word = '0;
	int          faults = 0;
	int          quiet_cycles = 0;
	int          idle_odds = 0;
	int          rx_hold = 0;
	script_row_t script [25];
	frame_plan_t plans [6];

	// Result word that one command word should give; updates the model state
	function automatic bin_word_t bin_command(logic [1:0] c, logic [PIX_W-1:0] ix,
			logic [TIME_BITS-1:0] tv);
		bin_word_t      w;
		bit [PIX_W-1:0] nxt;
		w = '0;
		case (c)
			CMD_LOAD: begin
				mark_time[int'(ix)] = tv;
			end
			CMD_START: begin
				pix_tally.delete();
				walk_ptr = PTR_W'(1);
				fold_pix = '0;
			end
			CMD_PHOT: begin
				// before boundary 0: bin 0, pointer untouched
				if (tv >= mark_time[0]) begin
					while (walk_ptr <= PTR_W'(n_pixels) &&
							tv >= mark_time[int'(walk_ptr[BND_AW-1:0])]) begin
						nxt = fold_pix + 1'b1;
						walk_ptr = walk_ptr + 1'b1;
						if (fold_len != 0 && PTR_W'(fold_pix) + 1 >= PTR_W'(fold_len))
							nxt = '0;
						fold_pix = nxt;
					end
					// past the last pixel nothing is counted
					if (walk_ptr <= PTR_W'(n_pixels)) begin
						if (int'(fold_pix) < MAX_PIXELS) begin
							if (!pix_tally.exists(int'(fold_pix)))
								pix_tally[int'(fold_pix)] = '0;
							if (pix_tally[int'(fold_pix)] != '1)
								pix_tally[int'(fold_pix)]++;
						end
						w.bin = fold_pix + 1'b1;
					end
				end
			end
			default: begin
				if (int'(ix) < MAX_PIXELS && pix_tally.exists(int'(ix)))
					w.cnt = pix_tally[int'(ix)];
			end
		endcase
		return w;
	endfunction

	function automatic logic [TIME_BITS-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_BITS-1:0];
	endfunction

	// Scoreboard and stall watchdog
	always @(posedge clk) begin
		bin_word_t got, w;
		if (arst_n) begin
			quiet_cycles++;
			if (cmd_ch.valid && cmd_ch.ready) begin
				w = bin_command(cmd_ch.cmd, cmd_ch.index, cmd_ch.time_value);
				if (pin_on)
					w = pin_word;
				due_words.push_back(w);
				quiet_cycles = 0;
			end
			if (res_ch.valid && res_ch.ready) begin
				quiet_cycles = 0;
				got.bin = res_ch.pixel_bin;
				got.cnt = res_ch.count_value;
				if (due_words.size() == 0) begin
					faults++;
					$display("%0t: stray result word, expected none, got bin %0d count %0d",
						$time, got.bin, got.cnt);
				end else begin
					w = due_words.pop_front();
					if (got.bin !== w.bin) begin
						faults++;
						$display("%0t: pixel_bin expected %0d, got %0d", $time, w.bin, got.bin);
					end
					if (got.cnt !== w.cnt) begin
						faults++;
						$display("%0t: count_value expected %0d, got %0d",
							$time, w.cnt, got.cnt);
					end
				end
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Result side back-pressure in random bursts
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			res_ch.ready <= 1'b0;
		end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
			rx_hold = $urandom_range(0, 6);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Offer one command word at a falling edge and hold it until taken
	task automatic push_word(logic [1:0] c, logic [PIX_W-1:0] ix, logic [TIME_BITS-1:0] tv,
			bit typed = 1'b0, bin_word_t want = '0);
		if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		pin_on = typed;
		pin_word = want;
		cmd_ch.valid <= 1'b1;
		cmd_ch.cmd <= c;
		cmd_ch.index <= ix;
		cmd_ch.time_value <= tv;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	// Stop sending and wait for every outstanding result word
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		pin_on = 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] r, logic [PIX_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		if (r == REG_PIXEL_COUNT)
			n_pixels = v;
		else
			fold_len = v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// One frame: registers, rising boundary grid, start, then a photon stream
	// mixed with reads, stray photons and boundary rewrites
	task automatic run_frame(frame_plan_t p);
		logic [TIME_BITS-1:0] grid [0:GRID_MAX];
		logic [63:0]          cursor, stride, t;
		logic [PIX_W-1:0]     ix;
		int                   span, top, pick;
		bit                   huge;
		huge = (int'(p.pixels) > GRID_MAX);
		// a huge frame gets a short grid capped by a mark no photon reaches
		span = huge ? 32 : int'(p.pixels);
		settle();
		idle_odds = p.idle;
		write_reg(REG_PIXEL_COUNT, p.pixels);
		write_reg(REG_FOLD_PERIOD, p.fold);
		grid[0] = rand48() >> $urandom_range(1, 47);
		stride = 64'd1 << $urandom_range(2, 36);
		for (int k = 1; k <= span; k++)
			grid[k] = grid[k-1] + 1 + (rand48() % stride);
		if (huge)
			grid[span] = T_MAX;
		for (int k = 0; k <= span; k++)
			push_word(CMD_LOAD, PIX_W'(k), grid[k]);
		push_word(CMD_START, PIX_W'($urandom), rand48());

		// photon steps sized so the stream runs a little past the last mark
		top = huge ? span - 1 : span;
		stride = (grid[top] - grid[0]) / (FRAME_WORDS / 4) + 1;
		cursor = (grid[0] > stride) ? grid[0] - stride : 64'd0;
		for (int i = 0; i < FRAME_WORDS; i++) begin
			if (p.refold && i == FRAME_WORDS / 2) begin
				settle();
				write_reg(REG_FOLD_PERIOD, p.fold_later);
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if (pick < 60) begin
					cursor = cursor + rand48() % (stride + 1);
					t = cursor;
				end else begin
					case ($urandom_range(0, 2))
						0: t = (grid[0] == 0) ? 64'd0 : rand48() % grid[0];
						1: t = cursor - rand48() % (cursor + 1);
						default: t = rand48();
					endcase
				end
				if (t > T_MAX)
					t = T_MAX;
				if (huge && t >= T_MAX)
					t = T_MAX - 1;
				push_word(CMD_PHOT, PIX_W'($urandom), t[TIME_BITS-1:0]);
			end else if (pick < 85) begin
				ix = ($urandom_range(0, 2) == 0) ? PIX_W'($urandom)
					: PIX_W'($urandom_range(0, span + 1));
				push_word(CMD_READ, ix, rand48());
			end else begin
				if (huge)
					ix = PIX_W'($urandom_range(0, span - 1));
				else
					ix = $urandom_range(0, 1) ? PIX_W'($urandom)
						: PIX_W'($urandom_range(0, span));
				push_word(CMD_LOAD, ix, rand48());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = CMD_LOAD;
		cmd_ch.index = '0;
		cmd_ch.time_value = '0;
		res_ch.ready = 1'b0;

		// Directed words: one-pixel frame after reset, then a folded frame
		script[0]  = '{ROW_CMD, CMD_READ,  16'd0,     48'd0,   1'b1, '{16'd0, 32'd0}};
		script[1]  = '{ROW_CMD, CMD_READ,  16'hFFFF,  48'd0,   1'b1, '{16'd0, 32'd0}};
		script[2]  = '{ROW_CMD, CMD_LOAD,  16'd0,     48'd100, 1'b1, '{16'd0, 32'd0}};
		script[3]  = '{ROW_CMD, CMD_LOAD,  16'd1,     48'd200, 1'b1, '{16'd0, 32'd0}};
		script[4]  = '{ROW_CMD, CMD_LOAD,  16'hFFFF,  T_MAX,   1'b1, '{16'd0, 32'd0}};
		script[5]  = '{ROW_CMD, CMD_PHOT,  16'd0,     48'd0,   1'b1, '{16'd0, 32'd0}};
		script[6]  = '{ROW_CMD, CMD_PHOT,  16'd0,     48'd99,  1'b1, '{16'd0, 32'd0}};
		script[7]  = '{ROW_CMD, CMD_PHOT,  16'd0,     48'd100, 1'b1, '{16'd1, 32'd0}};
		script[8]  = '{ROW_CMD, CMD_PHOT,  16'hFFFF,  48'd150, 1'b1, '{16'd1, 32'd0}};
		script[9]  = '{ROW_CMD, CMD_READ,  16'd0,     48'd0,   1'b1, '{16'd0, 32'd2}};
		script[10] = '{ROW_CMD, CMD_PHOT,  16'd0,     48'd200, 1'b1, '{16'd0, 32'd0}};
		script[11] = '{ROW_CMD, CMD_PHOT,  16'd0,     48'd120, 1'b1, '{16'd0, 32'd0}};
		script[12] = '{ROW_CMD, CMD_READ,  16'd0,     48'd0,   1'b1, '{16'd0, 32'd2}};
		script[13] = '{ROW_CMD, CMD_START, 16'd0,     48'd0,   1'b1, '{16'd0, 32'd0}};
		script[14] = '{ROW_CMD, CMD_READ,  16'd0,     48'd0,   1'b1, '{16'd0, 32'd0}};
		script[15] = '{ROW_CMD, CMD_PHOT,  16'd0,     T_MAX,   1'b1, '{16'd0, 32'd0}};
		script[16] = '{ROW_REG, CMD_LOAD,  PIX_W'(REG_PIXEL_COUNT), 48'd3, 1'b0, '0};
		script[17] = '{ROW_REG, CMD_LOAD,  PIX_W'(REG_FOLD_PERIOD), 48'd2, 1'b0, '0};
		script[18] = '{ROW_CMD, CMD_LOAD,  16'd2,     48'd300, 1'b1, '{16'd0, 32'd0}};
		script[19] = '{ROW_CMD, CMD_LOAD,  16'd3,     48'd400, 1'b1, '{16'd0, 32'd0}};
		script[20] = '{ROW_CMD, CMD_START, 16'd0,     48'd0,   1'b1, '{16'd0, 32'd0}};
		script[21] = '{ROW_CMD, CMD_PHOT,  16'd0,     48'd350, 1'b0, '0};
		script[22] = '{ROW_CMD, CMD_PHOT,  16'd0,     48'd50,  1'b0, '0};
		script[23] = '{ROW_CMD, CMD_PHOT,  16'd0,     48'd400, 1'b0, '0};
		script[24] = '{ROW_CMD, CMD_READ,  16'd0,     48'd0,   1'b0, '0};

		// Frames: empty frame, widest frame and fold, unit fold, fold changed
		// mid-frame both ways, and a last frame with no idling at all
		plans[0] = '{16'd0,     16'd0,     1'b0, 16'd0, 15};
		plans[1] = '{16'hFFFF,  16'hFFFF,  1'b0, 16'd0, 35};
		plans[2] = '{16'd1,     16'd1,     1'b0, 16'd0, 0};
		plans[3] = '{PIX_W'($urandom_range(2, GRID_MAX)), 16'd0, 1'b1,
			PIX_W'($urandom_range(1, 8)), 35};
		plans[4] = '{PIX_W'($urandom_range(2, GRID_MAX)), PIX_W'($urandom_range(1, 8)),
			1'b1, 16'd0, 15};
		plans[5] = '{PIX_W'($urandom_range(2, GRID_MAX)), PIX_W'($urandom_range(2, 65535)),
			1'b0, 16'd0, 0};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idle_odds = 20;

		foreach (script[i]) begin
			if (script[i].kind == ROW_REG) begin
				settle();
				write_reg(script[i].index[CFG_IDX_W-1:0], script[i].value[PIX_W-1:0]);
			end else begin
				push_word(script[i].cmd, script[i].index, script[i].value,
					script[i].typed, script[i].want);
			end
		end

		foreach (plans[i])
			run_frame(plans[i]);

		settle();
		if (faults == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/ptb_pkg.sv
rtl/ptb_if.sv
rtl/ptb_bound_store.sv
rtl/ptb_count_store.sv
rtl/photon_time_pixel_binner.sv
bench/tb.sv
